@@ rtl/mexp64_pkg.sv @@
// Shared types and constants for the 64-bit modular exponentiation core.
package mexp64_pkg;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned BIT_CNT_W = $clog2(WORD_W);

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type base_value;
      word_type exponent;
      word_type modulus;
   } req_data_type;

   typedef struct packed {
      word_type power_result;
      logic     zero_modulus_error;
   } rsp_data_type;

   // Command to the shared modular multiplier. The multiplicand must be below the modulus.
   typedef struct packed {
      logic     start;
      word_type multiplicand;
      word_type multiplier;
      word_type modulus;
   } mul_cmd_type;

   typedef struct packed {
      logic     done;
      word_type product;
   } mul_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL,
      ST_SQUARE,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/modular_exponentiation_64_core.sv @@
// Top level of the 64-bit modular exponentiation core: sequencer and result register.
//
// Channel  Direction  Handshake              Word contents
// req      in         req_valid / req_ready  base_value, exponent, modulus
// rsp      out        rsp_valid / rsp_ready  power_result, zero_modulus_error
//
// Run time from acceptance to rsp_valid grows with the exponent's bit length and number
// of set bits: each bit below the top costs a square, each set bit a multiply, and even a
// zero exponent runs the base reduction, all on the single bit-serial multiplier.
// A zero modulus skips all arithmetic; ST_FINISH then loads the result register.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// The next request is taken while a result waits in the output register; only the
// handoff of the following result stalls until rsp_ready frees that register.
module modular_exponentiation_64_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mexp64_pkg::req_data_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mexp64_pkg::rsp_data_type  rsp_data
);

   mexp64_pkg::state_type     state_ff, state_in;
   mexp64_pkg::word_type      exp_ff, exp_in;
   mexp64_pkg::word_type      mod_ff, mod_in;
   mexp64_pkg::word_type      acc_ff, acc_in;
   mexp64_pkg::word_type      sq_ff, sq_in;
   logic                      err_ff, err_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mexp64_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   mexp64_pkg::mul_cmd_type   mul_cmd;
   mexp64_pkg::mul_rsp_type   mul_rsp;
   mexp64_pkg::word_type      one_mod;
   logic                      req_take;
   logic                      rsp_free;

   // The single shared arithmetic unit: every modular product goes through it.
   mexp64_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   assign req_ready = (state_ff == mexp64_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // One modulo m: 1 for any modulus above 1, and 0 when the modulus is 1.
   assign one_mod = (req_data.modulus == mexp64_pkg::word_type'(1)) ? '0
                                                                    : mexp64_pkg::word_type'(1);

   always_comb begin
      state_in             = state_ff;
      exp_in               = exp_ff;
      mod_in               = mod_ff;
      acc_in               = acc_ff;
      sq_in                = sq_ff;
      err_in               = err_ff;
      mul_cmd.start        = 1'b0;
      mul_cmd.multiplicand = sq_ff;
      mul_cmd.multiplier   = sq_ff;
      mul_cmd.modulus      = mod_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_data_in          = rsp_data_ff;

      case (state_ff)
         mexp64_pkg::ST_IDLE: begin
            if (req_take) begin
               exp_in = req_data.exponent;
               mod_in = req_data.modulus;
               acc_in = one_mod;
               if (req_data.modulus == '0) begin
                  // Zero modulus: result forced to zero with the error flag.
                  err_in   = 1'b1;
                  acc_in   = '0;
                  state_in = mexp64_pkg::ST_FINISH;
               end else begin
                  // The base is reduced as (1 mod m) * base mod m, which needs no divider.
                  err_in               = 1'b0;
                  mul_cmd.start        = 1'b1;
                  mul_cmd.multiplicand = one_mod;
                  mul_cmd.multiplier   = req_data.base_value;
                  mul_cmd.modulus      = req_data.modulus;
                  state_in             = mexp64_pkg::ST_REDUCE;
               end
            end
         end
         mexp64_pkg::ST_REDUCE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               state_in = mexp64_pkg::ST_STEP;
            end
         end
         mexp64_pkg::ST_STEP: begin
            // Right-to-left scan: multiply when the low exponent bit is set, then square.
            if (exp_ff == '0) begin
               state_in = mexp64_pkg::ST_FINISH;
            end else if (exp_ff[0]) begin
               mul_cmd.start        = 1'b1;
               mul_cmd.multiplicand = acc_ff;
               state_in             = mexp64_pkg::ST_MUL;
            end else begin
               mul_cmd.start = 1'b1;
               state_in      = mexp64_pkg::ST_SQUARE;
            end
         end
         mexp64_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               if (exp_ff[mexp64_pkg::WORD_W-1:1] == '0) begin
                  // Last set bit: the trailing square cannot change the result.
                  state_in = mexp64_pkg::ST_FINISH;
               end else begin
                  mul_cmd.start = 1'b1;
                  state_in      = mexp64_pkg::ST_SQUARE;
               end
            end
         end
         mexp64_pkg::ST_SQUARE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               exp_in   = {1'b0, exp_ff[mexp64_pkg::WORD_W-1:1]};
               state_in = mexp64_pkg::ST_STEP;
            end
         end
         mexp64_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.power_result       = acc_ff;
               rsp_data_in.zero_modulus_error = err_ff;
               state_in                       = mexp64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp64_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp64_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/mexp64_mulmod.sv @@
// Bit-serial double-and-add modular multiplier, one multiplier bit per cycle.
module mexp64_mulmod (
   input  logic                     clock,
   input  logic                     reset,
   input  mexp64_pkg::mul_cmd_type  cmd,
   output mexp64_pkg::mul_rsp_type  rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [mexp64_pkg::BIT_CNT_W-1:0]    count_ff, count_in;
   mexp64_pkg::word_type                acc_ff, acc_in;
   mexp64_pkg::word_type                a_ff, a_in;
   mexp64_pkg::word_type                b_ff, b_in;
   mexp64_pkg::word_type                m_ff, m_in;

   logic [mexp64_pkg::WORD_W:0]         dbl_sum;
   logic [mexp64_pkg::WORD_W:0]         add_sum;
   mexp64_pkg::word_type                dbl_red;
   mexp64_pkg::word_type                add_red;
   mexp64_pkg::word_type                acc_step;
   logic                                last_bit;

   // One step: acc = 2*acc mod m, then plus a mod m when the top multiplier bit is set.
   always_comb begin
      dbl_sum = {acc_ff, 1'b0};
      if (dbl_sum >= {1'b0, m_ff}) begin
         dbl_red = mexp64_pkg::word_type'(dbl_sum - {1'b0, m_ff});
      end else begin
         dbl_red = dbl_sum[mexp64_pkg::WORD_W-1:0];
      end
      add_sum = {1'b0, dbl_red} + {1'b0, a_ff};
      if (add_sum >= {1'b0, m_ff}) begin
         add_red = mexp64_pkg::word_type'(add_sum - {1'b0, m_ff});
      end else begin
         add_red = add_sum[mexp64_pkg::WORD_W-1:0];
      end
      acc_step = b_ff[mexp64_pkg::WORD_W-1] ? add_red : dbl_red;
   end

   assign last_bit = (count_ff == mexp64_pkg::BIT_CNT_W'(mexp64_pkg::WORD_W - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         acc_in   = '0;
         a_in     = cmd.multiplicand;
         b_in     = cmd.multiplier;
         m_in     = cmd.modulus;
      end else if (busy_ff) begin
         acc_in   = acc_step;
         b_in     = {b_ff[mexp64_pkg::WORD_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      m_ff     <= m_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

@@ sim/mexp64_power_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the 64-bit modular exponentiation core: predicts each power and compares.
module mexp64_power_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  mexp64_pkg::req_data_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  mexp64_pkg::rsp_data_type rsp_data,
   output int                       words_in_flight,
   output int                       mismatch_count
);

   mexp64_pkg::rsp_data_type awaited_powers[$];

   // Exact modular product through the full 128-bit product.
   function automatic mexp64_pkg::word_type mul_mod_word(mexp64_pkg::word_type a,
                                                         mexp64_pkg::word_type b,
                                                         mexp64_pkg::word_type m);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      full = full % {64'd0, m};
      return full[63:0];
   endfunction

   function automatic mexp64_pkg::rsp_data_type predict_power(mexp64_pkg::req_data_type w);
      mexp64_pkg::rsp_data_type r;
      mexp64_pkg::word_type     acc;
      mexp64_pkg::word_type     sq;
      r.power_result       = '0;
      r.zero_modulus_error = 1'b0;
      if (w.modulus == '0) begin
         r.zero_modulus_error = 1'b1;
         return r;
      end
      acc = 64'd1 % w.modulus;
      sq  = w.base_value % w.modulus;
      for (int k = 0; k < 64; k++) begin
         if (w.exponent[k]) begin
            acc = mul_mod_word(acc, sq, w.modulus);
         end
         sq = mul_mod_word(sq, sq, w.modulus);
      end
      r.power_result = acc;
      return r;
   endfunction

   initial begin
      words_in_flight = 0;
      mismatch_count  = 0;
   end

   // Results are taken before requests: a word accepted at this edge cannot already be answered.
   always @(posedge clock) begin : watch
      mexp64_pkg::rsp_data_type want;
      int                       taken;
      int                       added;
      int                       bad;
      taken = 0;
      added = 0;
      bad   = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_powers.size() == 0) begin
               $error("unexpected result word: power_result=%h zero_modulus_error=%b",
                      rsp_data.power_result, rsp_data.zero_modulus_error);
               bad++;
            end else begin
               want  = awaited_powers.pop_front();
               taken = 1;
               if (rsp_data.power_result !== want.power_result) begin
                  $error("power_result: expected %h, actual %h",
                         want.power_result, rsp_data.power_result);
                  bad++;
               end
               if (rsp_data.zero_modulus_error !== want.zero_modulus_error) begin
                  $error("zero_modulus_error: expected %b, actual %b",
                         want.zero_modulus_error, rsp_data.zero_modulus_error);
                  bad++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_powers.push_back(predict_power(req_data));
            added = 1;
         end
      end
      words_in_flight <= words_in_flight + added - taken;
      mismatch_count  <= mismatch_count + bad;
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the 64-bit modular exponentiation core: stimulus, flow control and verdict.
module tb;

   localparam int RANDOM_WORDS = 67;
   // Length of the one long receiver hold-off, in cycles.
   localparam int HOLD_CYCLES  = 600;
   // Quiet time after the last result; covers the slowest word the core can take.
   localparam int TAIL_CYCLES  = 9000;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   mexp64_pkg::req_data_type req_data     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   mexp64_pkg::rsp_data_type rsp_data;
   logic                     hold_request = 1'b0;
   int                       words_in_flight;
   int                       mismatch_count;
   int                       burst_left   = 0;

   // 12 ns clock: 6 ns high, 6 ns low.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   modular_exponentiation_64_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The checker sees both channels exactly as the core does and reports back how many
   // words are still owed and how many mismatches it found.
   mexp64_power_checker power_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .words_in_flight (words_in_flight),
      .mismatch_count  (mismatch_count)
   );

   function automatic mexp64_pkg::word_type rand64();
      return {$urandom, $urandom};
   endfunction

   // Most random words use short exponents so the run stays quick; about one in eight
   // carries a full 64-bit exponent, which is the slow path through the core.
   function automatic mexp64_pkg::req_data_type random_word();
      mexp64_pkg::req_data_type w;
      int                       exp_bits;
      case ($urandom_range(0, 15))
         0:       w.modulus = '0;
         1:       w.modulus = 64'd1;
         2, 3:    w.modulus = 64'($urandom_range(2, 1000));
         4:       w.modulus = 64'd1 << $urandom_range(1, 63);
         5:       w.modulus = ~64'd0 - 64'($urandom_range(0, 255));
         default: w.modulus = rand64();
      endcase
      case ($urandom_range(0, 5))
         0:       w.base_value = 64'($urandom_range(0, 3));
         1:       w.base_value = ~64'd0;
         2:       w.base_value = (w.modulus != '0) ? rand64() % w.modulus : rand64();
         default: w.base_value = rand64();
      endcase
      if ($urandom_range(0, 7) == 0) begin
         w.exponent = rand64();
      end else begin
         exp_bits   = $urandom_range(0, 12);
         w.exponent = rand64() & ((64'd1 << exp_bits) - 64'd1);
      end
      return w;
   endfunction

   // Raises valid with the word and holds both until the core takes it. Called right
   // after a rising edge; returns at the edge where the word was accepted.
   task automatic push_word(input mexp64_pkg::req_data_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender in bursts: when a burst runs out, valid drops for a random gap and a new
   // burst length is drawn. Now and then a long burst gives a stretch with no idling.
   task automatic offer_word(input mexp64_pkg::req_data_type w);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      end
      burst_left--;
      push_word(w);
   endtask

   task automatic offer_triple(input mexp64_pkg::word_type b, input mexp64_pkg::word_type e,
                               input mexp64_pkg::word_type m);
      mexp64_pkg::req_data_type w;
      w.base_value = b;
      w.exponent   = e;
      w.modulus    = m;
      offer_word(w);
   endtask

   // Drops valid and waits until the checker owes nothing. The first edge lets the
   // checker's count take in the word accepted at the current edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   // Receiver: one long hold-off when the stimulus asks for it, otherwise a style that
   // is redrawn periodically among always ready, random stalls and a repeating mask.
   initial begin : receiver
      int         cycle;
      int         style;
      int         hold_left;
      bit         hold_taken;
      logic [7:0] ready_mask;
      cycle      = 0;
      style      = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      ready_mask = 8'hFF;
      forever begin
         @(posedge clock);
         if (cycle % 48 == 0) begin
            style      = $urandom_range(0, 2);
            ready_mask = 8'($urandom) | 8'h01;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ready_mask[cycle % 8];
            endcase
         end
         cycle++;
      end
   end

   initial begin : stimulus
      mexp64_pkg::req_data_type w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: zero modulus, modulus of one, zero exponent, base reduction,
      // and all-ones values in every field.
      offer_triple(rand64(), rand64(), 64'd0);
      offer_triple(64'd0, 64'd0, 64'd0);
      offer_triple(~64'd0, ~64'd0, 64'd0);
      offer_triple(64'd5, 64'd0, 64'd1);
      offer_triple(rand64(), 64'd77, 64'd1);
      offer_triple(rand64(), 64'd0, ~64'd0);
      offer_triple(64'd0, 64'd0, 64'd7);
      offer_triple(64'd0, 64'd5, ~64'd0);
      offer_triple(~64'd0, 64'd1, ~64'd0);
      offer_triple(~64'd0, 64'd2, ~64'd0 - 64'd1);
      offer_triple(64'd100, 64'd3, 64'd7);
      offer_triple(64'd2, 64'd64, ~64'd0);
      offer_triple(64'd1000, 64'd1, 64'd1000);
      offer_triple(64'd999, 64'd2, 64'd1000);
      offer_triple(64'd2, 64'd1, 64'd3);
      offer_triple(~64'd0, ~64'd0, ~64'd0);
      offer_triple(64'd3, ~64'd0, 64'h8000_0000_0000_0000);
      offer_triple(64'd2, ~64'd0 - 64'd60, ~64'd0 - 64'd58);
      offer_triple(64'd3, 64'h8000_0000_0000_0000, 64'd1_000_000_007);
      offer_triple(~64'd0, ~64'd0, 64'd2);
      offer_triple(rand64(), 64'hFFF, rand64() | 64'h8000_0000_0000_0001);

      // The sender pauses here until every directed result is back.
      wait_drained();

      // Long receiver hold-off while words keep coming without gaps: the output
      // register and the sequencer fill up and the core must stall its input.
      hold_request <= 1'b1;
      for (int k = 0; k < 12; k++) begin
         w = random_word();
         if (k % 2 == 0) begin
            w.modulus = '0;
         end else begin
            w.exponent = w.exponent & 64'hF;
         end
         push_word(w);
      end

      // Random part.
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         offer_word(random_word());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_in_flight == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Run limit: 60 ms, several times the slowest correct run with every word carrying
   // a full-width exponent.
   initial begin : watchdog
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
